// ----- rtl/mahd_pkg.sv -----
// Shared types and constants for the moving average hysteresis detector.
package mahd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int HYST_W   = 15;

    // Configuration register indexes
    localparam int   CFG_IDX_W      = 1;
    localparam logic CFG_THRESHOLD  = 1'b0;
    localparam logic CFG_HYSTERESIS = 1'b1;

    // Temperature scaling: raw / 34 + 365, truncated toward zero.
    // The divide is a multiply by ceil(2^21 / 34); the rounding error
    // stays below one LSB of the quotient for magnitudes up to 2^20.
    localparam int TEMP_DIVISOR = 34;
    localparam int TEMP_SHIFT   = 21;
    localparam int TEMP_MAG_W   = SAMPLE_W + 1;
    localparam int TEMP_RECIP_W = 16;
    localparam int TEMP_PROD_W  = TEMP_MAG_W + TEMP_RECIP_W;
    localparam int TEMP_Q_W     = 10;
    localparam logic [TEMP_RECIP_W-1:0] TEMP_RECIP =
        TEMP_RECIP_W'(((1 << TEMP_SHIFT) + TEMP_DIVISOR - 1) / TEMP_DIVISOR);
    localparam logic signed [SAMPLE_W-1:0] TEMP_OFFSET = 16'sd365;

    // Average quotient magnitude reaches 2^15, hence one extra bit
    localparam int AVG_Q_W = SAMPLE_W + 1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] raw_sample;
        logic                       is_temperature;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       above;
    } t_out_beat;

endpackage

// ----- rtl/mahd_window.sv -----
// Ring window store with registered read of the entry about to be replaced.
module mahd_window
    import mahd_pkg::*;
#(
    parameter int WINDOW_LEN = 20
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    output logic signed [SAMPLE_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic signed [SAMPLE_W-1:0] i_wr_data
);

    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

    logic signed [SAMPLE_W-1:0] r_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]      r_vld;
    logic [SLOT_W-1:0]          r_rd_slot;
    logic [SLOT_W-1:0]          r_wr_slot;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic                       r_rd_vld;
    logic [SLOT_W-1:0]          n_rd_slot;
    logic [SLOT_W-1:0]          n_wr_slot;

    assign n_rd_slot = (r_rd_slot == LAST_SLOT) ? '0 : r_rd_slot + 1'b1;
    assign n_wr_slot = (r_wr_slot == LAST_SLOT) ? '0 : r_wr_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_slot] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[r_rd_slot];
        end
    end

    // Valid bits stand in for clearing the store at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_slot <= '0;
            r_wr_slot <= '0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld  <= r_vld[r_rd_slot];
                r_rd_slot <= n_rd_slot;
            end
            if (i_wr_en) begin
                r_vld[r_wr_slot] <= 1'b1;
                r_wr_slot        <= n_wr_slot;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

    // At most one read may run ahead of its write
    a_slot_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_slot == r_wr_slot) || (r_rd_slot == n_wr_slot))
        else $error("window read slot drifted from write slot");

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> (r_rd_slot != r_wr_slot))
        else $error("window write without an earlier read");

    a_rd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && !i_wr_en) |-> (r_rd_slot == r_wr_slot))
        else $error("second window read issued before write");

endmodule

// ----- rtl/moving_average_hysteresis_detector_unit.sv -----
// Top level of the moving average hysteresis detector.
//
// Each input beat carries a signed 16-bit sample and a temperature flag; a
// flagged sample is scaled to raw/34+365. The sample replaces the oldest of
// WINDOW_LEN window entries, the running sum is updated, and the beat that
// comes out holds sum/WINDOW_LEN (truncated toward zero) and a Schmitt flag
// that sets above threshold+hysteresis and clears below threshold. The block
// takes one beat per clock while the output is not stalled; the rate is set
// by the running-sum update as a beat enters the third stage, which completes
// one window slot per cycle. The window reads as all zeros after reset
// through per-entry valid bits, so there is no clearing pass. Configuration
// writes take effect on the next cycle and belong in idle periods.
module moving_average_hysteresis_detector_unit
    import mahd_pkg::*;
#(
    parameter int WINDOW_LEN = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data
);

    localparam int WIN_LOG   = $clog2(WINDOW_LEN);
    localparam int SUM_W     = SAMPLE_W + WIN_LOG;
    localparam int AVG_SHIFT = SUM_W + WIN_LOG;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int APROD_W   = SUM_W + RECIP_W;
    // ceil(2^AVG_SHIFT / WINDOW_LEN): error times any sum magnitude < 2^AVG_SHIFT
    localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(
        ((64'd1 << AVG_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    // config
    logic signed [SAMPLE_W-1:0] r_threshold;
    logic [HYST_W-1:0]          r_hysteresis;

    // stage valids and handshake
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic w_ld1, w_ld2, w_ld3, w_ld4, w_ld5;

    // stage 1: input register, temperature multiply
    t_in_beat               r_s1_beat;
    logic [TEMP_MAG_W-1:0]  w_raw_mag;
    logic [TEMP_PROD_W-1:0] w_tprod;

    // stage 2: finish scaling, ring update
    logic                       r_s2_temp;
    logic                       r_s2_neg;
    logic signed [SAMPLE_W-1:0] r_s2_raw;
    logic [TEMP_Q_W-1:0]        r_s2_tq;
    logic signed [SAMPLE_W-1:0] w_tq_s;
    logic signed [SAMPLE_W-1:0] w_sample;
    logic signed [SAMPLE_W-1:0] w_old;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;

    // stage 3: average multiply
    logic               w_sum_neg;
    logic [SUM_W-1:0]   w_sum_mag;
    logic [APROD_W-1:0] w_aprod;

    // stage 4: sign, compare
    logic [AVG_Q_W-1:0]         r_s4_q;
    logic                       r_s4_neg;
    logic signed [SAMPLE_W-1:0] w_avg;
    logic signed [SAMPLE_W:0]   w_upper;
    logic signed [SAMPLE_W:0]   w_avg_x;
    logic signed [SAMPLE_W:0]   w_thr_x;
    logic                       n_above;

    // stage 5: output register
    t_out_beat r_s5_beat;
    logic      r_above;

    assign w_rdy5 = !r_v5 || !i_out_stall;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_ld1 = i_in_valid && w_rdy1;
    assign w_ld2 = r_v1 && w_rdy2;
    assign w_ld3 = r_v2 && w_rdy3;
    assign w_ld4 = r_v3 && w_rdy4;
    assign w_ld5 = r_v4 && w_rdy5;

    assign o_in_stall  = !w_rdy1;
    assign o_out_valid = r_v5;
    assign o_out_data  = r_s5_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= '0;
            r_hysteresis <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:  r_threshold  <= $signed(i_cfg_data);
                CFG_HYSTERESIS: r_hysteresis <= i_cfg_data[HYST_W-1:0];
            endcase
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_s1_beat <= i_in_data;
        end
    end

    assign w_raw_mag = r_s1_beat.raw_sample[SAMPLE_W-1]
                     ? TEMP_MAG_W'(0) - {1'b1, r_s1_beat.raw_sample}
                     : {1'b0, r_s1_beat.raw_sample};
    assign w_tprod = TEMP_PROD_W'(w_raw_mag) * TEMP_PROD_W'(TEMP_RECIP);

    // stage 2
    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_s2_temp <= r_s1_beat.is_temperature;
            r_s2_neg  <= r_s1_beat.raw_sample[SAMPLE_W-1];
            r_s2_raw  <= r_s1_beat.raw_sample;
            r_s2_tq   <= w_tprod[TEMP_SHIFT +: TEMP_Q_W];
        end
    end

    assign w_tq_s   = r_s2_neg ? SAMPLE_W'(0) - SAMPLE_W'(r_s2_tq) : SAMPLE_W'(r_s2_tq);
    assign w_sample = r_s2_temp ? w_tq_s + TEMP_OFFSET : r_s2_raw;

    mahd_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_ld2),
        .o_rd_data (w_old),
        .i_wr_en   (w_ld3),
        .i_wr_data (w_sample)
    );

    assign n_sum = r_sum
                 - {{(SUM_W-SAMPLE_W){w_old[SAMPLE_W-1]}}, w_old}
                 + {{(SUM_W-SAMPLE_W){w_sample[SAMPLE_W-1]}}, w_sample};

    // r_sum only moves when stage 2 hands over, so it is stage 3's payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (w_ld3) begin
            r_sum <= n_sum;
        end
    end

    // stage 3
    assign w_sum_neg = r_sum[SUM_W-1];
    assign w_sum_mag = w_sum_neg ? SUM_W'(0) - r_sum : r_sum;
    assign w_aprod   = APROD_W'(w_sum_mag) * APROD_W'(AVG_RECIP);

    // stage 4
    always_ff @(posedge i_clk) begin
        if (w_ld4) begin
            r_s4_q   <= w_aprod[AVG_SHIFT +: AVG_Q_W];
            r_s4_neg <= w_sum_neg;
        end
    end

    assign w_avg   = r_s4_neg ? SAMPLE_W'(AVG_Q_W'(0) - r_s4_q) : r_s4_q[SAMPLE_W-1:0];
    assign w_avg_x = {w_avg[SAMPLE_W-1], w_avg};
    assign w_thr_x = {r_threshold[SAMPLE_W-1], r_threshold};
    assign w_upper = w_thr_x + $signed({2'b00, r_hysteresis});

    always_comb begin
        n_above = r_above;
        priority if (w_avg_x > w_upper) begin
            n_above = 1'b1;
        end else if (w_avg_x < w_thr_x) begin
            n_above = 1'b0;
        end
    end

    // stage 5
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above <= 1'b0;
        end else if (w_ld5) begin
            r_above <= n_above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld5) begin
            r_s5_beat.average <= w_avg;
            r_s5_beat.above   <= n_above;
        end
    end

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5))
        else $error("input stalled with a bubble in the pipe");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_s2_temp) |-> ((w_sample >= -16'sd598) && (w_sample <= 16'sd1328)))
        else $error("scaled temperature out of range");

    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !r_v4) |=> !o_out_valid)
        else $error("output beat repeated after drain");

endmodule

// ----- tb/tb_moving_average_hysteresis_detector_unit.sv -----
// Testbench for the moving average hysteresis detector: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module tb_moving_average_hysteresis_detector_unit;
    import mahd_pkg::*;

    localparam int WINDOW_LEN   = 20;
    localparam int PHASE_COUNT  = 7;
    localparam int PHASE_ITEMS  = 200;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    // flag is the register index for ROW_CFG and the temperature bit for ROW_SAMPLE
    typedef struct packed {
        t_row_kind   kind;
        logic        flag;
        logic [15:0] value;
        logic        pinned;
        t_out_beat   want;
    } t_directed_row;

    typedef struct packed {
        logic      pinned;
        t_out_beat want;
    } t_pinned_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_beat             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_beat            o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SAMPLE_W-1:0]  i_cfg_data = '0;

    // predictor state
    int window_vals[WINDOW_LEN];
    int window_sum;
    int write_pos;
    int latest_mean;
    bit comparator_high;
    int threshold_reg;
    int hysteresis_reg;

    t_out_beat      pending_averages[$];
    t_pinned_result pinned_results[$];
    t_directed_row  directed_rows[$];

    int mismatch_count;
    int samples_taken;
    int temp_samples;
    int cfg_writes;
    int averages_checked;
    int comparator_flips;
    int gap_odds;
    int stall_odds;
    int stall_left;

    moving_average_hysteresis_detector_unit #(
        .WINDOW_LEN(WINDOW_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Folds one sample into the window and returns the average and comparator state.
    function automatic t_out_beat advance_window(input t_in_beat beat);
        int        value;
        int        upper;
        bit        prior;
        t_out_beat res;
        value = int'($signed(beat.raw_sample));
        if (beat.is_temperature) begin
            value = value / TEMP_DIVISOR + int'(TEMP_OFFSET);
        end
        window_sum = window_sum - window_vals[write_pos] + value;
        window_vals[write_pos] = value;
        write_pos = (write_pos == WINDOW_LEN - 1) ? 0 : write_pos + 1;
        latest_mean = window_sum / WINDOW_LEN;
        upper = threshold_reg + hysteresis_reg;
        prior = comparator_high;
        if (latest_mean > upper) begin
            comparator_high = 1'b1;
        end else if (latest_mean < threshold_reg) begin
            comparator_high = 1'b0;
        end
        if (prior != comparator_high) begin
            comparator_flips++;
        end
        res.average = latest_mean[15:0];
        res.above   = comparator_high;
        return res;
    endfunction

    task automatic log_mismatch(input string what, input t_out_beat want, input t_out_beat got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch (%s) at %0t: expected average %0d above %0b, %s %0d above %0b",
                     what, $time, want.average, want.above, "got average",
                     got.average, got.above);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_out_beat      want;
        t_out_beat      got;
        t_pinned_result pin;
        if (!i_rst_n) begin
            foreach (window_vals[k]) begin
                window_vals[k] = 0;
            end
            window_sum = 0;
            write_pos = 0;
            latest_mean = 0;
            comparator_high = 1'b0;
            threshold_reg = 0;
            hysteresis_reg = 0;
        end else begin
            if (i_cfg_we) begin
                cfg_writes++;
                if (i_cfg_index == CFG_THRESHOLD) begin
                    threshold_reg = int'($signed(i_cfg_data));
                end else begin
                    hysteresis_reg = int'({1'b0, i_cfg_data[HYST_W-1:0]});
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = advance_window(i_in_data);
                samples_taken++;
                if (i_in_data.is_temperature) begin
                    temp_samples++;
                end
                if (pinned_results.size() != 0) begin
                    pin = pinned_results.pop_front();
                    if (pin.pinned) begin
                        want = pin.want;
                    end
                end
                pending_averages.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (pending_averages.size() == 0) begin
                    log_mismatch("unexpected beat", '0, got);
                end else begin
                    want = pending_averages.pop_front();
                    averages_checked++;
                    if (got.average !== want.average || got.above !== want.above) begin
                        log_mismatch("field", want, got);
                    end
                end
            end
        end
    end

    // Output back-pressure: random stall bursts, each started with odds of 1 in stall_odds.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_sample(input logic [15:0] raw, input logic temp, input logic pinned,
                               input t_out_beat want);
        t_in_beat beat;
        beat.raw_sample     = raw;
        beat.is_temperature = temp;
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        pinned_results.push_back('{pinned, want});
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected beat is out and the pipe is empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_averages.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_directed_row row;
        int            level;
        int            smp;
        int            thr;
        int            hyst;
        logic [15:0]   hyst_word;
        logic          temp;
        int            phase;
        int            n;

        // Reset values: threshold 0, hysteresis 0, so both levels sit at zero.
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h0000, 1'b1, {16'sd0, 1'b0}});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h7FFF, 1'b1, {16'sd1638, 1'b1}});
        // sum -1 truncates to 0, equal to both levels: comparator holds
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h8000, 1'b1, {16'sd0, 1'b1}});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h8000, 1'b1, {-16'sd1638, 1'b0}});
        // temperature scaling, truncation toward zero on both signs
        directed_rows.push_back('{ROW_SAMPLE, 1'b1, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b1, 16'h7FFF, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b1, 16'h8000, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b1, 16'hFFDE, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b1, 16'hFFDF, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b1, 16'h0021, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h5555, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'hAAAA, 1'b0, '0});
        // bit 15 of the hysteresis word must be dropped
        directed_rows.push_back('{ROW_CFG, CFG_HYSTERESIS, 16'hFFFF, 1'b0, '0});
        directed_rows.push_back('{ROW_CFG, CFG_THRESHOLD, 16'h8000, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h0064, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'hFF9C, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h7FFF, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h7FFF, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h7FFF, 1'b0, '0});
        // the next two samples fill the ring; the samples after the register writes wrap it
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h7FFF, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h8000, 1'b0, '0});
        directed_rows.push_back('{ROW_CFG, CFG_THRESHOLD, 16'h7FFF, 1'b0, '0});
        directed_rows.push_back('{ROW_CFG, CFG_HYSTERESIS, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'h7FFF, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 1'b0, 16'hFFFF, 1'b0, '0});

        gap_odds   = 3;
        stall_odds = 3;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.flag, row.value);
            end else begin
                send_sample(row.value, row.flag, row.pinned, row.want);
            end
        end

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();
            case (phase)
                0: begin
                    gap_odds = 4; stall_odds = 4;
                end
                1: begin
                    gap_odds = 0; stall_odds = 0;
                end
                PHASE_COUNT - 1: begin
                    gap_odds = 0; stall_odds = 0;
                end
                default: begin
                    gap_odds   = 2 << $urandom_range(0, 2);
                    stall_odds = 2 << $urandom_range(0, 2);
                end
            endcase
            hyst = $urandom_range(0, 2000);
            case (phase)
                0: begin
                    thr = -32768;
                    hyst_word = 16'hFFFF;
                end
                1: begin
                    thr = 32767;
                    hyst_word = 16'h0000;
                end
                2: begin
                    // upper level placed exactly on the current average
                    thr = latest_mean - hyst;
                    if (thr < -32768) begin
                        thr  = latest_mean;
                        hyst = 0;
                    end
                    hyst_word = hyst[15:0];
                end
                3: begin
                    // lower level placed exactly on the current average
                    thr = latest_mean;
                    hyst_word = hyst[15:0];
                end
                default: begin
                    thr = int'($urandom_range(0, 12000)) - 6000;
                    hyst_word = {1'($urandom_range(0, 1)), 15'($urandom_range(0, 4000))};
                end
            endcase
            write_reg(CFG_THRESHOLD, thr[15:0]);
            write_reg(CFG_HYSTERESIS, hyst_word);
            level = (phase < 2) ? int'($urandom_range(0, 40000)) - 20000 : thr;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 0 && (phase == 2 || phase == 3)) begin
                    // replacing the oldest entry by itself keeps the average on the level
                    smp  = window_vals[write_pos];
                    temp = 1'b0;
                end else begin
                    level += int'($urandom_range(0, 600)) - 300;
                    if (level > 32767) level = 32767;
                    if (level < -32768) level = -32768;
                    temp = ($urandom_range(0, 3) == 0);
                    if ($urandom_range(0, 7) == 0) begin
                        smp = int'($signed(16'($urandom())));
                    end else begin
                        smp = level + int'($urandom_range(0, 3000)) - 1500;
                        if (smp > 32767) smp = 32767;
                        if (smp < -32768) smp = -32768;
                    end
                end
                send_sample(smp[15:0], temp, 1'b0, '0);
            end
        end

        settle();
        $display("Ran %0d samples (%0d temperature-scaled) over %0d register writes;",
                 samples_taken, temp_samples, cfg_writes);
        $display("checked %0d averages, comparator changed state %0d times.",
                 averages_checked, comparator_flips);
        if (mismatch_count == 0 && pending_averages.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
